// ===== design/vga_pkg.sv =====
// shared types, opcodes and saturation helper for the vector geometry unit
// no dependencies; imported by vga_isqrt, vga_div_lane and vector3_geometry_alu
package vga_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int FRONT_STAGES  = 6;
    localparam int SQ_RAD_W      = 64;
    localparam int SQ_ROOT_W     = 32;
    localparam int CFG_IDX_W     = 2;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_CROSS = 4'd2;
    localparam logic [3:0] OP_SCALE = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_DOT   = 4'd5;
    localparam logic [3:0] OP_LEN   = 4'd6;
    localparam logic [3:0] OP_NORM  = 4'd7;
    localparam logic [3:0] OP_DIST  = 4'd8;
    localparam logic [3:0] OP_CULL  = 4'd9;
    localparam logic [3:0] OP_LERP  = 4'd10;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CAM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z = 2'd2;

    localparam logic signed [65:0] S32_MAX_W = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN_W = -66'sd2147483648;

    typedef struct packed {
        logic        ovf;
        logic [31:0] val;
    } t_sat;

    // request state through the front and square-root stages
    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] v;
        logic [31:0]      scal;
        logic             culled;
        logic             sat;
        logic [2:0][31:0] a;
        logic [31:0]      t;
    } t_meta;

    // request state alongside the divider lanes
    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] v;
        logic [31:0]      scal;
        logic             culled;
        logic             sat;
        logic             err;
    } t_tail;

    typedef struct packed {
        logic [2:0][31:0] v;
        logic [31:0]      scal;
        logic             culled;
        logic [1:0]       status;
    } t_res;

    function automatic t_sat clamp32(input logic signed [65:0] v);
        t_sat r;
        if (v > S32_MAX_W) begin
            r.ovf = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end else if (v < S32_MIN_W) begin
            r.ovf = 1'b1;
            r.val = 32'h8000_0000;
        end else begin
            r.ovf = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/vga_isqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on vga_pkg
module vga_isqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [vga_pkg::SQ_RAD_W-1:0]  i_rad,
    output logic [vga_pkg::SQ_ROOT_W-1:0] o_root
);
    import vga_pkg::*;

    localparam int RW = SQ_ROOT_W + 2;

    logic [SQ_RAD_W-1:0]  r_rad  [SQ_ROOT_W];
    logic [SQ_ROOT_W-1:0] r_root [SQ_ROOT_W];
    logic [RW-1:0]        r_rem  [SQ_ROOT_W];

    for (genvar s = 0; s < SQ_ROOT_W; s++) begin : g_stg
        logic [SQ_RAD_W-1:0]  p_rad;
        logic [SQ_ROOT_W-1:0] p_root;
        logic [RW-1:0]        p_rem;
        logic [RW+1:0]        cur;
        logic [RW+1:0]        trial;
        logic [RW+1:0]        diff;
        logic                 ge;
        logic [SQ_RAD_W-1:0]  n_rad;
        logic [SQ_ROOT_W-1:0] n_root;
        logic [RW-1:0]        n_rem;

        if (s == 0) begin : g_first
            assign p_rad  = i_rad;
            assign p_root = '0;
            assign p_rem  = '0;
        end else begin : g_next
            assign p_rad  = r_rad[s-1];
            assign p_root = r_root[s-1];
            assign p_rem  = r_rem[s-1];
        end

        always_comb begin
            cur    = {p_rem, p_rad[SQ_RAD_W-1 -: 2]};
            trial  = {2'b00, p_root, 2'b01};
            diff   = cur - trial;
            ge     = (cur >= trial);
            n_rem  = ge ? diff[RW-1:0] : cur[RW-1:0];
            n_root = {p_root[SQ_ROOT_W-2:0], ge};
            n_rad  = {p_rad[SQ_RAD_W-3:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s]  <= n_rad;
                r_root[s] <= n_root;
                r_rem[s]  <= n_rem;
            end
        end
    end

    assign o_root = r_root[SQ_ROOT_W-1];

endmodule

// ===== design/vga_div_lane.sv =====
// one divider lane: pipelined restoring unsigned division, one quotient bit per stage
// depends on vga_pkg
module vga_div_lane #(
    parameter int NUM_W = 32 + vga_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [31:0]      i_den,
    input  logic             i_neg,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_neg
);
    import vga_pkg::*;

    logic [31:0]      r_rem [NUM_W];
    logic [NUM_W-1:0] r_dq  [NUM_W];
    logic [31:0]      r_den [NUM_W];
    logic             r_neg [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stg
        logic [31:0]      p_rem;
        logic [NUM_W-1:0] p_dq;
        logic [31:0]      p_den;
        logic             p_neg;
        logic [32:0]      cur;
        logic [32:0]      diff;
        logic             ge;

        if (s == 0) begin : g_first
            assign p_rem = '0;
            assign p_dq  = i_num;
            assign p_den = i_den;
            assign p_neg = i_neg;
        end else begin : g_next
            assign p_rem = r_rem[s-1];
            assign p_dq  = r_dq[s-1];
            assign p_den = r_den[s-1];
            assign p_neg = r_neg[s-1];
        end

        always_comb begin
            cur  = {p_rem, p_dq[NUM_W-1]};
            diff = cur - {1'b0, p_den};
            ge   = (cur >= {1'b0, p_den});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? diff[31:0] : cur[31:0];
                r_dq[s]  <= {p_dq[NUM_W-2:0], ge};
                r_den[s] <= p_den;
                r_neg[s] <= p_neg;
            end
        end
    end

    assign o_quo = r_dq[NUM_W-1];
    assign o_neg = r_neg[NUM_W-1];

endmodule

// ===== design/vector3_geometry_alu.sv =====
// request to result: the front stages, then the 32-stage square-root pipeline, then the
// one-bit-per-stage divider lanes, then the output queue (numbers are Q16.16 by default)
// throughput: one request per cycle; a two-entry output queue keeps intake going
// while a result waits, and the whole pipeline holds only when that queue is full
// reset: synchronous active-low, clears stage valid bits, queue count and camera
// registers; datapath registers are not reset
module vector3_geometry_alu #(
    parameter int FRAC_BITS = vga_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [vga_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [3:0]                    i_req_type,
    input  logic signed [31:0]            i_a_x,
    input  logic signed [31:0]            i_a_y,
    input  logic signed [31:0]            i_a_z,
    input  logic signed [31:0]            i_b_x,
    input  logic signed [31:0]            i_b_y,
    input  logic signed [31:0]            i_b_z,
    input  logic signed [31:0]            i_c_x,
    input  logic signed [31:0]            i_c_y,
    input  logic signed [31:0]            i_c_z,
    input  logic signed [31:0]            i_scalar_t,
    input  logic signed [31:0]            i_scale_s,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [31:0]            o_out_x,
    output logic signed [31:0]            o_out_y,
    output logic signed [31:0]            o_out_z,
    output logic signed [31:0]            o_out_scalar,
    output logic                          o_culled,
    output logic [1:0]                    o_status
);
    import vga_pkg::*;

    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int NSTG  = FRONT_STAGES + SQ_ROOT_W + NUM_W;

    // ---------------- control ----------------
    logic            en;
    logic            acc;
    logic            push;
    logic            pop;
    logic [NSTG-1:0] r_vld;
    logic [1:0]      r_cnt;
    logic            r_wp;
    logic            r_rp;
    t_res            r_q [2];
    t_res            fin;
    t_res            head;

    assign en      = (r_cnt != 2'd2);
    assign acc     = i_valid && en;
    assign o_stall = !en;
    assign push    = en && r_vld[NSTG-1];
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[NSTG-2:0], acc};
            end
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= fin;
        end
    end

    assign head         = r_q[r_rp];
    assign o_out_x      = signed'(head.v[0]);
    assign o_out_y      = signed'(head.v[1]);
    assign o_out_z      = signed'(head.v[2]);
    assign o_out_scalar = signed'(head.scal);
    assign o_culled     = head.culled;
    assign o_status     = head.status;

    // ---------------- camera registers ----------------
    logic signed [31:0] r_cam [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam[0] <= '0;
            r_cam[1] <= '0;
            r_cam[2] <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CAM_X: r_cam[0] <= signed'(i_cfg_wr_data);
                CFG_CAM_Y: r_cam[1] <= signed'(i_cfg_wr_data);
                CFG_CAM_Z: r_cam[2] <= signed'(i_cfg_wr_data);
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: lane adds ----------------
    logic signed [31:0] ia [3];
    logic signed [31:0] ib [3];
    logic signed [31:0] ic [3];
    t_sat               f_add [3];
    t_sat               f_sub [3];
    t_sat               f_e1  [3];
    t_sat               f_e2  [3];
    t_sat               f_wc  [3];
    t_sat               f_d   [3];

    t_meta              n1_meta;
    logic signed [31:0] n1_x [3];
    logic signed [31:0] n1_y [3];
    t_meta              r1_meta;
    logic signed [31:0] r1_x [3];
    logic signed [31:0] r1_y [3];
    logic signed [31:0] r1_b [3];
    logic signed [31:0] r1_w [3];
    logic signed [31:0] r1_s;

    assign ia[0] = i_a_x;
    assign ia[1] = i_a_y;
    assign ia[2] = i_a_z;
    assign ib[0] = i_b_x;
    assign ib[1] = i_b_y;
    assign ib[2] = i_b_z;
    assign ic[0] = i_c_x;
    assign ic[1] = i_c_y;
    assign ic[2] = i_c_z;

    always_comb begin
        n1_meta    = '0;
        n1_meta.op = i_req_type;
        n1_meta.t  = i_scalar_t;
        for (int i = 0; i < 3; i++) begin
            f_add[i] = clamp32(66'(ia[i]) + 66'(ib[i]));
            f_sub[i] = clamp32(66'(ia[i]) - 66'(ib[i]));
            f_e1[i]  = clamp32(66'(ic[i]) - 66'(ia[i]));
            f_e2[i]  = clamp32(66'(ib[i]) - 66'(ia[i]));
            f_wc[i]  = clamp32(66'(ia[i]) - 66'(r_cam[i]));
            f_d[i]   = clamp32(66'(ic[i]) - 66'(ib[i]));
            n1_meta.a[i] = ia[i];
            n1_x[i] = ia[i];
            n1_y[i] = ib[i];
            unique case (i_req_type)
                OP_ADD: begin
                    n1_meta.v[i] = f_add[i].val;
                    n1_meta.sat  = n1_meta.sat | f_add[i].ovf;
                end
                OP_SUB: begin
                    n1_meta.v[i] = f_sub[i].val;
                    n1_meta.sat  = n1_meta.sat | f_sub[i].ovf;
                end
                OP_LEN, OP_NORM: begin
                    n1_y[i] = ia[i];
                end
                OP_DIST: begin
                    n1_x[i]     = signed'(f_sub[i].val);
                    n1_y[i]     = signed'(f_sub[i].val);
                    n1_meta.sat = n1_meta.sat | f_sub[i].ovf;
                end
                OP_CULL: begin
                    n1_x[i]     = signed'(f_e1[i].val);
                    n1_y[i]     = signed'(f_e2[i].val);
                    n1_meta.sat = n1_meta.sat | f_e1[i].ovf | f_e2[i].ovf | f_wc[i].ovf;
                end
                OP_SCALE: begin
                    n1_y[i] = i_scalar_t;
                end
                OP_LERP: begin
                    n1_x[i]     = signed'(f_d[i].val);
                    n1_y[i]     = i_scalar_t;
                    n1_meta.sat = n1_meta.sat | f_d[i].ovf;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_meta <= n1_meta;
            r1_s    <= i_scale_s;
            for (int i = 0; i < 3; i++) begin
                r1_x[i] <= n1_x[i];
                r1_y[i] <= n1_y[i];
                r1_b[i] <= ib[i];
                r1_w[i] <= signed'(f_wc[i].val);
            end
        end
    end

    // ---------------- stage 2: lane multipliers ----------------
    logic signed [31:0] ml [3];
    logic signed [31:0] mr [3];
    logic signed [63:0] n2_pa [3];
    logic signed [63:0] n2_pb [3];
    t_meta              r2_meta;
    logic signed [63:0] r2_pa [3];
    logic signed [63:0] r2_pb [3];
    logic signed [31:0] r2_b [3];
    logic signed [31:0] r2_w [3];
    logic signed [31:0] r2_s;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ml[i] = r1_x[i];
            mr[i] = r1_y[i];
            // cross terms: lane i takes x[i+1]*y[i+2] - x[i+2]*y[i+1]
            if (r1_meta.op == OP_CROSS || r1_meta.op == OP_CULL) begin
                ml[i] = r1_x[(i == 2) ? 0 : i + 1];
                mr[i] = r1_y[(i == 0) ? 2 : i - 1];
            end
            n2_pa[i] = ml[i] * mr[i];
            n2_pb[i] = r1_x[(i == 0) ? 2 : i - 1] * r1_y[(i == 2) ? 0 : i + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_meta <= r1_meta;
            r2_s    <= r1_s;
            for (int i = 0; i < 3; i++) begin
                r2_pa[i] <= n2_pa[i];
                r2_pb[i] <= n2_pb[i];
                r2_b[i]  <= r1_b[i];
                r2_w[i]  <= r1_w[i];
            end
        end
    end

    // ---------------- stage 3: rescale, cross difference, lerp add ----------------
    logic signed [63:0] sha [3];
    logic signed [63:0] shb [3];
    t_sat               g_nd [3];
    t_sat               g_q  [3];
    t_sat               g_r  [3];
    t_meta              n3_meta;
    logic signed [31:0] n3_m [3];
    t_meta              r3_meta;
    logic signed [31:0] r3_m  [3];
    logic signed [63:0] r3_dp [3];
    logic [63:0]        r3_sq [3];
    logic signed [31:0] r3_w  [3];
    logic signed [31:0] r3_s;

    always_comb begin
        n3_meta = r2_meta;
        for (int i = 0; i < 3; i++) begin
            sha[i]  = r2_pa[i] >>> FRAC_BITS;
            shb[i]  = r2_pb[i] >>> FRAC_BITS;
            g_nd[i] = clamp32(66'(sha[i]) - 66'(shb[i]));
            g_q[i]  = clamp32(66'(sha[i]));
            g_r[i]  = clamp32(66'(signed'(g_q[i].val)) + 66'(r2_b[i]));
            n3_m[i] = '0;
            unique case (r2_meta.op)
                OP_CROSS: begin
                    n3_meta.v[i] = g_nd[i].val;
                    n3_meta.sat  = n3_meta.sat | g_nd[i].ovf;
                end
                OP_CULL: begin
                    n3_m[i]     = signed'(g_nd[i].val);
                    n3_meta.sat = n3_meta.sat | g_nd[i].ovf;
                end
                OP_SCALE: begin
                    n3_meta.v[i] = g_q[i].val;
                    n3_meta.sat  = n3_meta.sat | g_q[i].ovf;
                end
                OP_LERP: begin
                    n3_m[i]     = signed'(g_r[i].val);
                    n3_meta.sat = n3_meta.sat | g_q[i].ovf | g_r[i].ovf;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_meta <= n3_meta;
            r3_s    <= r2_s;
            for (int i = 0; i < 3; i++) begin
                r3_m[i]  <= n3_m[i];
                r3_dp[i] <= sha[i];
                r3_sq[i] <= 64'(r2_pa[i]);
                r3_w[i]  <= r2_w[i];
            end
        end
    end

    // ---------------- stage 4: second multipliers, dot and square merge ----------------
    t_sat               g_dot;
    t_meta              n4_meta;
    logic signed [63:0] n4_pr [3];
    t_meta              r4_meta;
    logic signed [63:0] r4_pr [3];
    logic [63:0]        r4_sum;

    always_comb begin
        n4_meta = r3_meta;
        for (int i = 0; i < 3; i++) begin
            if (r3_meta.op == OP_CULL) begin
                n4_pr[i] = r3_w[i] * r3_m[i];
            end else begin
                n4_pr[i] = r3_m[i] * r3_s;
            end
        end
        g_dot = clamp32(66'(r3_dp[0]) + 66'(r3_dp[1]) + 66'(r3_dp[2]));
        if (r3_meta.op == OP_DOT) begin
            n4_meta.scal = g_dot.val;
            n4_meta.sat  = n4_meta.sat | g_dot.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_meta <= n4_meta;
            r4_sum  <= r3_sq[0] + r3_sq[1] + r3_sq[2];
            for (int i = 0; i < 3; i++) begin
                r4_pr[i] <= n4_pr[i];
            end
        end
    end

    // ---------------- stage 5: lerp result, cull rescale ----------------
    logic signed [63:0] shp [3];
    t_sat               g_l [3];
    t_meta              n5_meta;
    t_meta              r5_meta;
    logic signed [63:0] r5_cs [3];
    logic [63:0]        r5_sum;

    always_comb begin
        n5_meta = r4_meta;
        for (int i = 0; i < 3; i++) begin
            shp[i] = r4_pr[i] >>> FRAC_BITS;
            g_l[i] = clamp32(66'(shp[i]));
            if (r4_meta.op == OP_LERP) begin
                n5_meta.v[i] = g_l[i].val;
                n5_meta.sat  = n5_meta.sat | g_l[i].ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_meta <= n5_meta;
            r5_sum  <= r4_sum;
            for (int i = 0; i < 3; i++) begin
                r5_cs[i] <= shp[i];
            end
        end
    end

    // ---------------- stage 6: cull merge ----------------
    t_sat  g_cl;
    t_meta n6_meta;
    t_meta r6_meta;
    logic [63:0] r6_sum;

    always_comb begin
        n6_meta = r5_meta;
        g_cl    = clamp32(66'(r5_cs[0]) + 66'(r5_cs[1]) + 66'(r5_cs[2]));
        if (r5_meta.op == OP_CULL) begin
            n6_meta.culled = g_cl.val[31] || (g_cl.val == 32'd0);
            n6_meta.sat    = n6_meta.sat | g_cl.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_meta <= n6_meta;
            r6_sum  <= r5_sum;
        end
    end

    // ---------------- square root ----------------
    logic [SQ_ROOT_W-1:0] root;
    t_meta                r_sm [SQ_ROOT_W];

    vga_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r6_sum),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sm[0] <= r6_meta;
            for (int k = 1; k < SQ_ROOT_W; k++) begin
                r_sm[k] <= r_sm[k-1];
            end
        end
    end

    // ---------------- divider setup ----------------
    t_meta            sm;
    t_tail            n_tail;
    logic [31:0]      den;
    logic [31:0]      tmag;
    logic [31:0]      amag [3];
    logic [NUM_W-1:0] num  [3];
    logic             dneg [3];
    logic [NUM_W-1:0] quo  [3];
    logic             qneg [3];
    t_tail            r_dm [NUM_W];

    always_comb begin
        sm            = r_sm[SQ_ROOT_W-1];
        n_tail.op     = sm.op;
        n_tail.v      = sm.v;
        n_tail.scal   = sm.scal;
        n_tail.culled = sm.culled;
        n_tail.sat    = sm.sat;
        n_tail.err    = 1'b0;
        tmag          = sm.t[31] ? (~sm.t + 32'd1) : sm.t;
        den           = tmag;
        if (sm.op == OP_LEN || sm.op == OP_DIST) begin
            if (root[31]) begin
                n_tail.scal = 32'h7FFF_FFFF;
                n_tail.sat  = 1'b1;
            end else begin
                n_tail.scal = root;
            end
        end
        if (sm.op == OP_NORM) begin
            den         = root;
            n_tail.err  = (root == '0);
        end
        if (sm.op == OP_DIV) begin
            n_tail.err = (sm.t == 32'd0);
        end
        for (int i = 0; i < 3; i++) begin
            amag[i] = sm.a[i][31] ? (~sm.a[i] + 32'd1) : sm.a[i];
            num[i]  = {amag[i], {FRAC_BITS{1'b0}}};
            dneg[i] = sm.a[i][31] ^ ((sm.op == OP_DIV) && sm.t[31]);
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        vga_div_lane #(
            .NUM_W (NUM_W)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (num[l]),
            .i_den (den),
            .i_neg (dneg[l]),
            .o_quo (quo[l]),
            .o_neg (qneg[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dm[0] <= n_tail;
            for (int k = 1; k < NUM_W; k++) begin
                r_dm[k] <= r_dm[k-1];
            end
        end
    end

    // ---------------- result merge ----------------
    t_tail dm;
    logic  fsat;
    logic  qhi [3];

    always_comb begin
        dm         = r_dm[NUM_W-1];
        fin.v      = dm.v;
        fin.scal   = dm.scal;
        fin.culled = dm.culled;
        fsat       = dm.sat;
        for (int i = 0; i < 3; i++) begin
            qhi[i] = |quo[i][NUM_W-1:32];
            if (dm.op == OP_DIV || dm.op == OP_NORM) begin
                if (dm.err) begin
                    fin.v[i] = '0;
                end else if (qneg[i]) begin
                    // magnitude 2^31 still fits as the most negative value
                    if (qhi[i] || (quo[i][31] && (quo[i][30:0] != '0))) begin
                        fin.v[i] = 32'h8000_0000;
                        fsat     = 1'b1;
                    end else begin
                        fin.v[i] = ~quo[i][31:0] + 32'd1;
                    end
                end else begin
                    if (qhi[i] || quo[i][31]) begin
                        fin.v[i] = 32'h7FFF_FFFF;
                        fsat     = 1'b1;
                    end else begin
                        fin.v[i] = quo[i][31:0];
                    end
                end
            end
        end
        if (dm.err) begin
            fin.status = ST_ZERO;
        end else if (fsat) begin
            fin.status = ST_SAT;
        end else begin
            fin.status = ST_OK;
        end
    end

    // ---------------- assertions ----------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_cnt == 2'd0) && (r_vld == '0))
        else $error("pipeline not empty after reset");

    a_zero_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && fin.status == ST_ZERO) |-> (fin.v == '0) && !fin.culled)
        else $error("error result carries data");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> (r_cnt == 2'd2))
        else $error("full queue changed without a pop");

endmodule
